// ===== sv/htdr_pkg.sv =====
// Shared types and constants for the depth-replacement hash table.
package htdr_pkg;

  // Slot count; a power of two so the slot index is the low key bits
  localparam int unsigned TABLE_ENTRIES = 1024;
  localparam int unsigned IDX_W = $clog2(TABLE_ENTRIES);

  // Input word action codes
  localparam logic [1:0] ACT_PROBE = 2'd0;
  localparam logic [1:0] ACT_STORE = 2'd1;
  localparam logic [1:0] ACT_CLEAR = 2'd2;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP
  } htdr_state_t;

  // One table slot
  typedef struct packed {
    logic [63:0]       key;
    logic [31:0]       move;
    logic signed [31:0] score;
    logic signed [7:0] depth;
    logic [7:0]        flags;
    logic [7:0]        age;
  } htdr_slot_t;

  // Controller to datapath
  typedef struct packed {
    logic capture;
    logic load_out;
    logic store_eval;
    logic clr_step;
  } htdr_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic [1:0] action;
    logic       out_busy;
    logic       clr_last;
  } htdr_sts_t;

endpackage

// ===== sv/htdr_ctrl.sv =====
// Sequencing state machine for the depth-replacement hash table.
module htdr_ctrl import htdr_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  htdr_sts_t sts,
  output htdr_cmd_t cmd
);

  htdr_state_t state;
  htdr_state_t state_next;

  // State register; reset starts with a sweep that empties the table
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (sts.clr_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) state_next = ST_LOOKUP;
      end
      ST_LOOKUP: begin
        case (sts.action)
          ACT_PROBE: begin
            if (!sts.out_busy) state_next = ST_IDLE;
          end
          ACT_CLEAR: state_next = ST_CLEAR;
          default:   state_next = ST_IDLE;
        endcase
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    in_stall       = 1'b1;
    cmd            = '0;
    case (state)
      ST_CLEAR: begin
        cmd.clr_step = 1'b1;
      end
      ST_IDLE: begin
        in_stall    = 1'b0;
        cmd.capture = in_valid;
      end
      ST_LOOKUP: begin
        cmd.load_out   = (sts.action == ACT_PROBE) && !sts.out_busy;
        cmd.store_eval = (sts.action == ACT_STORE);
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

endmodule

// ===== sv/htdr_datapath.sv =====
// Slot memory, held word, replacement decision and result register.
module htdr_datapath import htdr_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  htdr_cmd_t          cmd,
  output htdr_sts_t          sts,
  input  logic               cfg_we,
  input  logic [7:0]         cfg_data,
  input  logic [1:0]         action,
  input  logic [63:0]        key,
  input  logic [31:0]        best_move,
  input  logic signed [31:0] score,
  input  logic signed [7:0]  search_depth,
  input  logic [7:0]         bound_flags,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               hit,
  output logic [31:0]        found_move,
  output logic signed [31:0] found_score,
  output logic signed [7:0]  found_depth,
  output logic [7:0]         found_flags,
  output logic [7:0]         found_age
);

  htdr_slot_t mem [TABLE_ENTRIES];
  htdr_slot_t rd_slot;
  htdr_slot_t wr_slot;
  logic [IDX_W-1:0] wr_idx;
  logic             wr_en;
  logic [IDX_W-1:0] clr_idx;
  logic [7:0]       search_age;

  logic [1:0]        h_action;
  logic [63:0]       h_key;
  logic [31:0]       h_move;
  logic signed [31:0] h_score;
  logic signed [7:0] h_depth;
  logic [7:0]        h_flags;

  logic slot_hit;
  logic replace;

  // Age register written from the configuration channel
  always_ff @(posedge clk) begin
    if (rst) begin
      search_age <= '0;
    end else if (cfg_we) begin
      search_age <= cfg_data;
    end
  end

  // Hold the accepted word and read its slot
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      h_action <= action;
      h_key    <= key;
      h_move   <= best_move;
      h_score  <= score;
      h_depth  <= search_depth;
      h_flags  <= bound_flags;
      rd_slot  <= mem[key[IDX_W-1:0]];
    end
  end

  // Replace an empty slot, a shallower one, or an equal-depth one from another age
  assign slot_hit = (rd_slot.key == h_key);
  assign replace  = (rd_slot.key == 64'd0)
                 || (h_depth > rd_slot.depth)
                 || ((h_depth == rd_slot.depth) && (rd_slot.age != search_age));

  // Single write port shared by the clear sweep and stores
  always_comb begin
    wr_en  = cmd.clr_step || (cmd.store_eval && replace);
    wr_idx = cmd.clr_step ? clr_idx : h_key[IDX_W-1:0];
    if (cmd.clr_step) begin
      wr_slot = '0;
    end else begin
      wr_slot.key   = h_key;
      wr_slot.move  = h_move;
      wr_slot.score = h_score;
      wr_slot.depth = h_depth;
      wr_slot.flags = h_flags;
      wr_slot.age   = search_age;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= wr_slot;
    end
  end

  // Clear sweep index; wraps back to zero after the last slot
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_idx <= '0;
    end else if (cmd.clr_step) begin
      clr_idx <= clr_idx + 1'b1;
    end
  end

  // Result register: load on probe, drop when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      hit         <= slot_hit;
      found_move  <= slot_hit ? rd_slot.move  : '0;
      found_score <= slot_hit ? rd_slot.score : '0;
      found_depth <= slot_hit ? rd_slot.depth : '0;
      found_flags <= slot_hit ? rd_slot.flags : '0;
      found_age   <= slot_hit ? rd_slot.age   : '0;
    end
  end

  // Status back to the controller
  assign sts.action   = h_action;
  assign sts.out_busy = out_valid && out_stall;
  assign sts.clr_last = (clr_idx == {IDX_W{1'b1}});

endmodule

// ===== sv/hash_table_depth_replace_core.sv =====
// Top level of the depth-replacement hash table.
//
//   channel  direction  handshake             payload
//   in       input      in_valid / in_stall   action, key, best_move, score,
//                                             search_depth, bound_flags
//   out      output     out_valid / out_stall hit, found_move, found_score,
//                                             found_depth, found_flags, found_age
//   cfg      input      cfg_valid / cfg_ready cfg_data (current age)
//
// Probe and store each begin with a registered read of the slot memory, then
// the result load or the conditional write through the single write port.
// Clear makes the same read, then sweeps all 1024 slots, one slot per cycle.
// After reset the same sweep runs before the first word is taken.
// A probe whose result cannot be loaded because the result word is stalled
// holds in the lookup state; stores and clears do not wait on the output.
module hash_table_depth_replace_core import htdr_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         action,
  input  logic [63:0]        key,
  input  logic [31:0]        best_move,
  input  logic signed [31:0] score,
  input  logic signed [7:0]  search_depth,
  input  logic [7:0]         bound_flags,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               hit,
  output logic [31:0]        found_move,
  output logic signed [31:0] found_score,
  output logic signed [7:0]  found_depth,
  output logic [7:0]         found_flags,
  output logic [7:0]         found_age,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [7:0]         cfg_data
);

  htdr_cmd_t cmd;
  htdr_sts_t sts;

  // Configuration writes are always taken
  assign cfg_ready = 1'b1;

  htdr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  htdr_datapath u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .cfg_we       (cfg_valid && cfg_ready),
    .cfg_data     (cfg_data),
    .action       (action),
    .key          (key),
    .best_move    (best_move),
    .score        (score),
    .search_depth (search_depth),
    .bound_flags  (bound_flags),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .hit          (hit),
    .found_move   (found_move),
    .found_score  (found_score),
    .found_depth  (found_depth),
    .found_flags  (found_flags),
    .found_age    (found_age)
  );

  // One word in flight: a capture is never followed directly by another
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    cmd.capture |=> !cmd.capture)
    else $error("word captured while previous word still in flight");

  // Results come only from probes
  a_load_is_probe: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> (sts.action == ACT_PROBE))
    else $error("result loaded for a non-probe word");

  // Never overwrite a stalled result word
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> !(out_valid && out_stall))
    else $error("result word overwritten while stalled");

  // Clear sweep and store never share the write port
  a_port_excl: assert property (@(posedge clk) disable iff (rst)
    cmd.clr_step |-> !(cmd.store_eval || cmd.capture))
    else $error("clear sweep overlaps store or capture");

endmodule

// ===== tb/htdr_lookup_checker.sv =====
`timescale 1ns / 1ps
// Lookup checker: mirrors the slot table, predicts each probe and checks the result channel.
module htdr_lookup_checker import htdr_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [1:0]         action,
  input  logic [63:0]        key,
  input  logic [31:0]        best_move,
  input  logic signed [31:0] score,
  input  logic signed [7:0]  search_depth,
  input  logic [7:0]         bound_flags,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic               hit,
  input  logic [31:0]        found_move,
  input  logic signed [31:0] found_score,
  input  logic signed [7:0]  found_depth,
  input  logic [7:0]         found_flags,
  input  logic [7:0]         found_age,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [7:0]         cfg_data,
  output int                 fails,
  output int                 pending
);

  typedef struct packed {
    logic              hit;
    logic [31:0]       move;
    logic signed [31:0] score;
    logic signed [7:0] depth;
    logic [7:0]        flags;
    logic [7:0]        age;
  } lookup_t;

  htdr_slot_t  slots [TABLE_ENTRIES];
  logic [7:0]  age_now;
  lookup_t     lookups_due [$];
  lookup_t     want;
  lookup_t     seen;

  function automatic void wipe_slots();
    foreach (slots[i]) slots[i] = '0;
  endfunction

  // Probe: hit when the stored key matches, stored contents on a hit, zeros otherwise
  function automatic lookup_t probe_slot(logic [63:0] k);
    htdr_slot_t s;
    lookup_t    r;
    s = slots[k[IDX_W-1:0]];
    r = '0;
    if (s.key == k) begin
      r.hit   = 1'b1;
      r.move  = s.move;
      r.score = s.score;
      r.depth = s.depth;
      r.flags = s.flags;
      r.age   = s.age;
    end
    return r;
  endfunction

  // Replace an empty slot, a shallower one, or an equal-depth one from another generation
  function automatic logic takes_slot(htdr_slot_t s, logic signed [7:0] d);
    if (s.key == '0) return 1'b1;
    if ($signed(d) > $signed(s.depth)) return 1'b1;
    return (d == s.depth) && (s.age != age_now);
  endfunction

  function automatic void store_slot(logic [63:0] k, logic [31:0] mv, logic signed [31:0] sc,
                                     logic signed [7:0] dp, logic [7:0] fl);
    logic [IDX_W-1:0] idx;
    idx = k[IDX_W-1:0];
    if (takes_slot(slots[idx], dp)) begin
      slots[idx].key   = k;
      slots[idx].move  = mv;
      slots[idx].score = sc;
      slots[idx].depth = dp;
      slots[idx].flags = fl;
      slots[idx].age   = age_now;
    end
  endfunction

  function automatic void check_field(string name, logic [63:0] want_v, logic [63:0] got_v);
    if (want_v !== got_v) begin
      fails++;
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want_v, got_v);
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      wipe_slots();
      age_now = '0;
      lookups_due.delete();
    end else begin
      // Age register write
      if (cfg_valid && cfg_ready) age_now = cfg_data;

      // Result word: compare with the oldest outstanding probe
      if (out_valid && !out_stall) begin
        seen = '{hit, found_move, found_score, found_depth, found_flags, found_age};
        if (lookups_due.size() == 0) begin
          fails++;
          $display("%0t: result word with no probe outstanding, expected none, got %h",
                   $time, seen);
        end else begin
          want = lookups_due.pop_front();
          check_field("hit", 64'(want.hit), 64'(seen.hit));
          check_field("found_move", 64'(want.move), 64'(seen.move));
          check_field("found_score", 64'(want.score), 64'(seen.score));
          check_field("found_depth", 64'(want.depth), 64'(seen.depth));
          check_field("found_flags", 64'(want.flags), 64'(seen.flags));
          check_field("found_age", 64'(want.age), 64'(seen.age));
        end
      end

      // Input word: advance the table mirror
      if (in_valid && !in_stall) begin
        case (action)
          ACT_PROBE: lookups_due.push_back(probe_slot(key));
          ACT_STORE: store_slot(key, best_move, score, search_depth, bound_flags);
          ACT_CLEAR: wipe_slots();
          default: ;
        endcase
      end
    end
    pending = lookups_due.size();
  end

endmodule

// ===== tb/hash_table_depth_replace_core_tb.sv =====
`timescale 1ns / 1ps
// Testbench top: drives table probes, stores, clears and age writes, and reports the verdict.
module hash_table_depth_replace_core_tb;
  import htdr_pkg::*;

  // Action code the block must ignore
  localparam logic [1:0] ACT_IGNORED = 2'd3;

  localparam int SWEEP_CYCLES = TABLE_ENTRIES + 64;
  localparam int PHASE_WORDS  = 180;

  localparam int STALL_NONE  = 0;
  localparam int STALL_LIGHT = 1;
  localparam int STALL_HEAVY = 2;

  localparam logic [63:0] KEY_A    = 64'h0123_4567_89ab_c003;
  localparam logic [63:0] KEY_B    = 64'hfedc_ba98_7654_3003;
  localparam logic [63:0] KEY_C    = 64'h0000_0000_0000_0400;
  localparam logic [63:0] KEY_ONES = 64'hffff_ffff_ffff_ffff;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [1:0]         action = ACT_PROBE;
  logic [63:0]        key = '0;
  logic [31:0]        best_move = '0;
  logic signed [31:0] score = '0;
  logic signed [7:0]  search_depth = '0;
  logic [7:0]         bound_flags = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic               hit;
  logic [31:0]        found_move;
  logic signed [31:0] found_score;
  logic signed [7:0]  found_depth;
  logic [7:0]         found_flags;
  logic [7:0]         found_age;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [7:0]         cfg_data = '0;

  int fails;
  int pending;

  int          burst_left = 0;
  int          stall_mode = STALL_NONE;
  int          stall_run = 0;
  logic [63:0] key_pool [32];
  int unsigned hot_slots [7] = '{0, 1, 3, 511, 512, 1022, 1023};

  hash_table_depth_replace_core dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .action(action), .key(key), .best_move(best_move), .score(score),
    .search_depth(search_depth), .bound_flags(bound_flags),
    .out_valid(out_valid), .out_stall(out_stall),
    .hit(hit), .found_move(found_move), .found_score(found_score),
    .found_depth(found_depth), .found_flags(found_flags), .found_age(found_age),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  htdr_lookup_checker u_checker (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .action(action), .key(key), .best_move(best_move), .score(score),
    .search_depth(search_depth), .bound_flags(bound_flags),
    .out_valid(out_valid), .out_stall(out_stall),
    .hit(hit), .found_move(found_move), .found_score(found_score),
    .found_depth(found_depth), .found_flags(found_flags), .found_age(found_age),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .fails(fails), .pending(pending)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Result stall: stretches of no stall, light stall and heavy stall
  always @(negedge clk) begin
    if (stall_run == 0) begin
      stall_mode = $urandom_range(STALL_NONE, STALL_HEAVY);
      stall_run  = $urandom_range(10, 150);
    end
    stall_run--;
    case (stall_mode)
      STALL_NONE:  out_stall <= 1'b0;
      STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
      default:     out_stall <= ($urandom_range(0, 3) != 0);
    endcase
  end

  initial begin
    #10_000_000;
    $display("hash_table_depth_replace_core_tb: FAIL");
    $finish;
  end

  // Send one word; open a new burst after a random gap when the current one runs out
  task automatic put_word(input logic [1:0] act, input logic [63:0] k, input logic [31:0] mv,
                          input logic signed [31:0] sc, input logic signed [7:0] dp,
                          input logic [7:0] fl);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    @(negedge clk);
    in_valid     <= 1'b1;
    action       <= act;
    key          <= k;
    best_move    <= mv;
    score        <= sc;
    search_depth <= dp;
    bound_flags  <= fl;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic probe(input logic [63:0] k);
    put_word(ACT_PROBE, k, $urandom, $urandom, 8'($urandom), 8'($urandom));
  endtask

  // Hold the input side idle until every probe result is back
  task automatic wait_results();
    @(negedge clk);
    in_valid <= 1'b0;
    burst_left = 0;
    while (pending != 0) @(negedge clk);
  endtask

  // Drain results, then leave room for a clear sweep still running
  task automatic settle();
    wait_results();
    repeat (SWEEP_CYCLES) @(negedge clk);
  endtask

  task automatic write_age(input logic [7:0] v);
    settle();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Mostly keys from a small pool that collides on a few slots
  function automatic logic [63:0] pick_key();
    int r;
    r = $urandom_range(0, 99);
    if (r < 78) return key_pool[$urandom_range(0, 31)];
    if (r < 90) return {$urandom, $urandom};
    if (r < 95) return '0;
    return KEY_ONES;
  endfunction

  // Depths clustered near zero so ties are common, plus extremes
  function automatic logic signed [7:0] pick_depth();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 8'($signed($urandom_range(0, 4)) - 2);
    if (r < 75) return $urandom_range(0, 1) ? 8'sh80 : 8'sh7f;
    return 8'($urandom);
  endfunction

  task automatic store_random(input logic [63:0] k);
    put_word(ACT_STORE, k, $urandom, $urandom, pick_depth(), 8'($urandom_range(0, 255)));
  endtask

  // Random traffic: store-then-probe pairs are most common, plus loose probes, stores, clears and ignored words
  task automatic run_random_phase(input int n_words);
    int          done_cnt;
    int          r;
    logic [63:0] k;
    done_cnt = 0;
    while (done_cnt < n_words) begin
      r = $urandom_range(0, 99);
      k = pick_key();
      if (r < 35) begin
        store_random(k);
        probe(k);
        done_cnt += 2;
      end else if (r < 62) begin
        probe(k);
        done_cnt++;
      end else if (r < 92) begin
        store_random(k);
        done_cnt++;
      end else if (r < 94) begin
        put_word(ACT_CLEAR, k, $urandom, $urandom, 8'($urandom), 8'($urandom));
        done_cnt++;
      end else begin
        put_word(ACT_IGNORED, k, $urandom, $urandom, 8'($urandom), 8'($urandom));
      end
      if ($urandom_range(0, 119) == 0) wait_results();
    end
  endtask

  initial begin
    for (int i = 0; i < 32; i++) begin
      key_pool[i] = {$urandom, $urandom};
      key_pool[i][IDX_W-1:0] = (i % 8 < 7) ? IDX_W'(hot_slots[i % 8])
                                           : IDX_W'($urandom_range(0, 1023));
    end

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed checks at the reset age
    probe('0);
    probe(KEY_ONES);
    put_word(ACT_STORE, KEY_A, 32'hffff_ffff, 32'sh8000_0000, 8'sd5, 8'hff);
    probe(KEY_A);
    put_word(ACT_STORE, KEY_B, 32'h1111_1111, 32'sd1, 8'sd5, 8'h01);
    put_word(ACT_STORE, KEY_B, 32'h2222_2222, 32'sd2, 8'sd4, 8'h02);
    probe(KEY_A);
    put_word(ACT_STORE, KEY_B, 32'h3333_3333, 32'sd3, 8'sd6, 8'h03);
    probe(KEY_A);
    probe(KEY_B);
    put_word(ACT_STORE, '0, 32'h0, 32'sh7fff_ffff, 8'sh80, 8'h00);
    probe('0);
    put_word(ACT_STORE, KEY_C, 32'hc0de_0001, -32'sd5, 8'sh80, 8'h5a);
    probe(KEY_C);
    put_word(ACT_IGNORED, KEY_B, 32'hdead_beef, -32'sd1, 8'sh7f, 8'hff);
    probe(KEY_B);
    put_word(ACT_STORE, KEY_ONES, 32'h1234_5678, -32'sd1, 8'sh7f, 8'ha5);
    probe(KEY_ONES);
    put_word(ACT_CLEAR, '0, '0, '0, '0, '0);
    probe(KEY_B);
    probe('0);
    probe(KEY_ONES);

    // Random phases, each under a new age
    write_age(8'd255);
    run_random_phase(PHASE_WORDS);
    write_age(8'd0);
    run_random_phase(PHASE_WORDS);
    write_age(8'd128);
    run_random_phase(PHASE_WORDS);
    write_age(8'($urandom_range(2, 254)));
    run_random_phase(PHASE_WORDS);
    write_age(8'd1);
    run_random_phase(PHASE_WORDS);

    settle();
    if (fails == 0) begin
      $display("hash_table_depth_replace_core_tb: PASS");
    end else begin
      $display("hash_table_depth_replace_core_tb: FAIL");
    end
    $finish;
  end

endmodule
